[hdl/rta_pkg.sv]
// Shared types, constants and operation codes for the run time accounting block.
`default_nettype none
package rta_pkg;
  localparam int TASK_COUNT = 64;
  localparam int TASK_W     = 6;
  localparam int TICK_W     = 32;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;

  // Divider geometry: numerator 2000*R+W fits 43 bits, denominator 2*W fits 33 bits.
  localparam int NUM_W  = 43;
  localparam int DEN_W  = 33;
  localparam int QSTEPS = 11;
  localparam int QW     = 10;
  localparam int CNT_W  = 4;
  localparam logic [QW-1:0] PM_MAX = QW'(1000);

  localparam logic [OP_W-1:0] OP_INIT        = 3'd0;
  localparam logic [OP_W-1:0] OP_START       = 3'd1;
  localparam logic [OP_W-1:0] OP_END         = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY       = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP_TOTAL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP_RECENT = 3'd5;

  localparam logic [ST_W-1:0] ST_OK          = 2'd0;
  localparam logic [ST_W-1:0] ST_START_BUSY  = 2'd1;
  localparam logic [ST_W-1:0] ST_END_IDLE    = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO_WINDOW = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] recent;
    logic [TICK_W-1:0] total;
  } rta_entry_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] q;
  } rta_div_res_t;
endpackage
`default_nettype wire

[hdl/per_task_run_time_accounting.sv]
// Init, start and rejected operations are emitted directly; end first reads the counter
// memory and writes it back; a usage query reads, multiplies and then runs the 11-step
// serial divider, which is skipped when the share saturates before dividing. Dumps read
// each of the 64 entries through the single read port of the counter memory, then emit it.
// One operation is in flight at a time. Reset clears control state; per-entry
// valid bits make both tables read as zero immediately, so no clearing pass is needed.
`default_nettype none
module per_task_run_time_accounting
  import rta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // operation[2:0], task_req[8:3], now[40:9], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // value[31:0], task_out[37:32], zero pad
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser   // status[1:0]
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_END_RD   = 4'd1;
  localparam logic [3:0] S_END_WR   = 4'd2;
  localparam logic [3:0] S_Q_RD     = 4'd3;
  localparam logic [3:0] S_Q_MUL    = 4'd4;
  localparam logic [3:0] S_Q_GO     = 4'd5;
  localparam logic [3:0] S_Q_WAIT   = 4'd6;
  localparam logic [3:0] S_DUMP_RD  = 4'd7;
  localparam logic [3:0] S_DUMP_OUT = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  localparam logic [10:0] PM_TWICE = 11'd2000;

  logic [3:0]            state;
  logic [OP_W-1:0]       op_l;
  logic [TASK_W-1:0]     task_l;
  logic [TICK_W-1:0]     now_l;
  logic [TICK_W-1:0]     win;
  logic [TICK_W-1:0]     elapsed;
  logic                  running;
  logic [TICK_W-1:0]     istart;
  logic [TICK_W-1:0]     wstart;
  logic [TASK_COUNT-1:0] tot_vld;
  logic [TASK_COUNT-1:0] rec_vld;
  logic [TASK_W-1:0]     idx;
  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      prod;
  logic [TICK_W-1:0]     res_value;
  logic [TASK_W-1:0]     res_task;
  logic [ST_W-1:0]       res_status;

  logic [OP_W-1:0]       op_in;
  logic [TASK_W-1:0]     task_in;
  logic [TICK_W-1:0]     now_in;
  logic                  s_fire;
  logic                  task_ok_in;
  logic                  task_ok_l;
  logic                  out_free;
  logic                  out_load;
  logic                  last_entry;
  logic [TICK_W-1:0]     old_total;
  logic [TICK_W-1:0]     old_recent;
  logic [TICK_W-1:0]     dump_val;

  logic                  ram_we;
  logic                  ram_re;
  logic [TASK_W-1:0]     ram_raddr;
  rta_entry_t            ram_wdata;
  rta_entry_t            ram_rdata;
  logic                  div_start;
  rta_div_res_t          div_res;

  assign op_in    = s_axis_tdata[2:0];
  assign task_in  = s_axis_tdata[8:3];
  assign now_in   = s_axis_tdata[40:9];

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = ((state == S_EMIT) || (state == S_DUMP_OUT)) && out_free;

  assign task_ok_in = ({1'b0, task_in} < (TASK_W+1)'(TASK_COUNT));
  assign task_ok_l  = ({1'b0, task_l} < (TASK_W+1)'(TASK_COUNT));
  assign last_entry = (idx == TASK_W'(TASK_COUNT - 1));

  // Entries whose valid bit is clear read as zero.
  assign old_total  = tot_vld[task_l] ? ram_rdata.total : '0;
  assign old_recent = (task_ok_l && rec_vld[task_l]) ? ram_rdata.recent : '0;
  assign dump_val   = (op_l == OP_DUMP_TOTAL) ? (tot_vld[idx] ? ram_rdata.total : '0)
                                              : (rec_vld[idx] ? ram_rdata.recent : '0);
  assign prod       = old_recent * PM_TWICE;

  assign ram_we           = (state == S_END_WR);
  assign ram_wdata.total  = old_total + elapsed;
  assign ram_wdata.recent = old_recent + elapsed;
  assign ram_re    = (state == S_END_RD) || (state == S_Q_RD) || (state == S_DUMP_RD);
  assign ram_raddr = (state == S_DUMP_RD) ? idx : task_l;
  assign div_start = (state == S_Q_GO);

  rta_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (task_l),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rta_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   ({win, 1'b0}),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      istart        <= '0;
      wstart        <= '0;
      tot_vld       <= '0;
      rec_vld       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            op_l       <= op_in;
            task_l     <= task_in;
            now_l      <= now_in;
            res_value  <= '0;
            res_task   <= '0;
            res_status <= ST_OK;
            idx        <= '0;
            case (op_in)
              OP_INIT: begin
                tot_vld <= '0;
                rec_vld <= '0;
                wstart  <= now_in;
                running <= 1'b0;
                state   <= S_EMIT;
              end
              OP_START: begin
                if (running) begin
                  res_status <= ST_START_BUSY;
                end else begin
                  running <= 1'b1;
                  istart  <= now_in;
                end
                state <= S_EMIT;
              end
              OP_END: begin
                res_task <= task_in;
                if (!running) begin
                  res_status <= ST_END_IDLE;
                  state      <= S_EMIT;
                end else begin
                  running <= 1'b0;
                  elapsed <= now_in - istart;
                  state   <= task_ok_in ? S_END_RD : S_EMIT;
                end
              end
              OP_QUERY: begin
                res_task <= task_in;
                if (now_in == wstart) begin
                  res_status <= ST_ZERO_WINDOW;
                  state      <= S_EMIT;
                end else begin
                  win   <= now_in - wstart;
                  state <= S_Q_RD;
                end
              end
              OP_DUMP_TOTAL, OP_DUMP_RECENT: begin
                state <= S_DUMP_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_END_RD: begin
          state <= S_END_WR;
        end
        S_END_WR: begin
          tot_vld[task_l] <= 1'b1;
          rec_vld[task_l] <= 1'b1;
          state           <= S_EMIT;
        end
        S_Q_RD: begin
          state <= S_Q_MUL;
        end
        S_Q_MUL: begin
          num   <= prod + NUM_W'(win);
          state <= S_Q_GO;
        end
        S_Q_GO: begin
          state <= S_Q_WAIT;
        end
        S_Q_WAIT: begin
          if (div_res.done) begin
            res_value <= TICK_W'(div_res.q);
            wstart    <= now_l;
            rec_vld   <= '0;
            state     <= S_EMIT;
          end
        end
        S_DUMP_RD: begin
          state <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            m_axis_tdata[31:0]  <= dump_val;
            m_axis_tdata[37:32] <= idx;
            m_axis_tdata[39:38] <= 2'b00;
            m_axis_tlast        <= last_entry;
            m_axis_tuser        <= ST_OK;
            // Drop the recent count as it leaves.
            if (op_l == OP_DUMP_RECENT) begin
              rec_vld[idx] <= 1'b0;
            end
            if (last_entry) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DUMP_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tdata[31:0]  <= res_value;
            m_axis_tdata[37:32] <= res_task;
            m_axis_tdata[39:38] <= 2'b00;
            m_axis_tlast        <= 1'b1;
            m_axis_tuser        <= res_status;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == S_Q_WAIT)
    else $error("divider finished outside of a usage query");

  a_write_after_end: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !running && op_l == OP_END)
    else $error("counter write without a completed interval");

  a_partial_only_dump: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (state == S_DUMP_RD || state == S_DUMP_OUT))
    else $error("non-final result outside of a dump");
`endif
endmodule
`default_nettype wire

[hdl/rta_ram.sv]
// Per-task counter memory: one write port, one registered read port.
`default_nettype none
module rta_ram
  import rta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [TASK_W-1:0] waddr,
  input  wire rta_entry_t        wdata,
  input  wire logic              re,
  input  wire logic [TASK_W-1:0] raddr,
  output rta_entry_t             rdata
);
  rta_entry_t mem [TASK_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[hdl/rta_div.sv]
// Restoring divider for the per-mille share, one quotient bit per cycle, saturated.
`default_nettype none
module rta_div
  import rta_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output rta_div_res_t          res
);
  logic              busy;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [QSTEPS-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              ge;
  logic              ovf;
  logic [QSTEPS-1:0] quo_next;
  logic              done;
  logic [QW-1:0]     q;

  assign res      = '{done: done, q: q};
  assign ge       = (rem >= dsh);
  assign quo_next = {quo[QSTEPS-2:0], ge};
  // A quotient of 2048 or more cannot be built bit by bit; it saturates anyway.
  assign ovf      = ({1'b0, num} >= {den, {QSTEPS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (ovf) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {(QSTEPS-1){1'b0}}};
      quo <= '0;
      cnt <= CNT_W'(QSTEPS - 1);
      q   <= PM_MAX;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= quo_next;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        q <= (quo_next > QSTEPS'(PM_MAX)) ? PM_MAX : quo_next[QW-1:0];
      end
    end
  end
endmodule
`default_nettype wire
